### hw/rtl/bb3s_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bb3s_pkg: shared types and constants of the 3x3 box blur stream
// Pixel and dimension widths, register indexes and the divide-by-nine constant.
// ----------------------------------------------------------------------------
package bb3s_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned DIM_W = 11;
  // Sum of nine 8-bit pixels fits in 12 bits (max 2295).
  localparam int unsigned SUM_W = 12;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned MIN_DIM        = 3;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1024);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1024);

  // floor(s / 9) == (s * 7282) >> 16 for every s <= 2295
  localparam int unsigned DIV9_SHIFT = 16;
  localparam int unsigned DIV9_W     = 13;
  localparam logic [DIV9_W-1:0] DIV9_RECIP = DIV9_W'(7282);
  localparam int unsigned PROD_W = SUM_W + DIV9_W;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

endpackage : bb3s_pkg
`default_nettype wire

### hw/rtl/box_blur_3x3_stream.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_stream: 3x3 box filter over a raster pixel stream
// Two line stores and a 3x3 window; one blurred pixel per interior position.
// ----------------------------------------------------------------------------
// Takes 8-bit pixels in raster order and gives, for each interior pixel, the
// floor of its 3x3 neighborhood mean; border positions give no result, and
// the last interior result of a frame carries frame_end. A pixel is accepted
// every cycle unless out_stall_i holds a full pipeline: the line stores are
// simple dual-port RAMs whose read for the next column is issued on the same
// edge that writes the current one, the nine-pixel sum is registered, and the
// divide by nine (a reciprocal multiply) fills the output register. Width and
// height must be written through the config port only while the stream is
// idle; the block does not enforce this. Values below 3 act as 3, values above
// MAX_WIDTH / MAX_HEIGHT act as the maximum. Line-store contents are undefined
// after reset and are only used once written by the first two rows of a frame.
module box_blur_3x3_stream #(
  parameter int unsigned MAX_WIDTH  = bb3s_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bb3s_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // pixel input
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [bb3s_pkg::PIX_W-1:0]  pixel_in_i,
  // result output
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [bb3s_pkg::PIX_W-1:0]       blurred_pixel_o,
  output logic                             frame_end_o,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire bb3s_pkg::cfg_idx_e          cfg_idx_i,
  input  wire logic [bb3s_pkg::DIM_W-1:0]  cfg_data_i
);

  localparam int unsigned PIX_W = bb3s_pkg::PIX_W;
  localparam int unsigned DIM_W = bb3s_pkg::DIM_W;
  localparam int unsigned SUM_W = bb3s_pkg::SUM_W;
  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CMPW_A = (CW > RW) ? CW + 2 : RW + 2;
  localparam int unsigned CMPW   = (CMPW_A > DIM_W + 1) ? CMPW_A : DIM_W + 1;

  localparam logic [CMPW-1:0] MINC  = CMPW'(bb3s_pkg::MIN_DIM);
  localparam logic [CMPW-1:0] MAXWC = CMPW'(MAX_WIDTH);
  localparam logic [CMPW-1:0] MAXHC = CMPW'(MAX_HEIGHT);
  localparam logic [CW-1:0]   COL_LAST_MAX = CW'(MAX_WIDTH - 1);
  localparam logic [RW-1:0]   ROW_LAST_MAX = RW'(MAX_HEIGHT - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bb3s_pkg::WIDTH_RST;
      height_q <= bb3s_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bb3s_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        bb3s_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CMPW-1:0] width_ext, height_ext, width_eff, height_eff;

  always_comb begin
    width_ext  = CMPW'(width_q);
    height_ext = CMPW'(height_q);
    if (width_ext < MINC) begin
      width_eff = MINC;
    end else if (width_ext > MAXWC) begin
      width_eff = MAXWC;
    end else begin
      width_eff = width_ext;
    end
    if (height_ext < MINC) begin
      height_eff = MINC;
    end else if (height_ext > MAXHC) begin
      height_eff = MAXHC;
    end else begin
      height_eff = height_ext;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  logic             s1_valid_q;
  logic [SUM_W-1:0] s1_sum_q;
  logic             s1_fend_q;
  logic             out_valid_q;
  logic             s1_move, s1_free, in_xfer;

  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_free    = !s1_valid_q || s1_move;
  assign in_stall_o = !s1_free;
  assign in_xfer    = in_valid_i && s1_free;

  // --------------------------------------------------------------------------
  // Position counters
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          last_col, last_row, res_hit;

  assign last_col = (CMPW'(col_q) + CMPW'(1)) >= width_eff;
  assign last_row = (CMPW'(row_q) + CMPW'(1)) >= height_eff;
  assign res_hit  = (CMPW'(col_q) >= CMPW'(2)) && (CMPW'(row_q) >= CMPW'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_xfer) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line stores: read data always tracks the column of the next pixel
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] ls_upper [MAX_WIDTH];
  logic [PIX_W-1:0] ls_middle[MAX_WIDTH];
  logic [PIX_W-1:0] up_rd_q, mid_rd_q;

  // col_d never equals col_q on a transfer (width >= 3), so no read/write clash
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ls_upper[col_q]  <= mid_rd_q;
      ls_middle[col_q] <= pixel_in_i;
    end
    up_rd_q  <= ls_upper[col_d];
    mid_rd_q <= ls_middle[col_d];
  end

  // --------------------------------------------------------------------------
  // Window: [0..2] column c-1 (upper, middle, current), [3..5] column c-2
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] win_q[6];
  logic [SUM_W-1:0] sum_d;

  always_comb begin
    sum_d = SUM_W'(up_rd_q) + SUM_W'(mid_rd_q) + SUM_W'(pixel_in_i);
    for (int k = 0; k < 6; k++) begin
      sum_d = sum_d + SUM_W'(win_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        win_q[k] <= '0;
      end
    end else if (in_xfer) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= up_rd_q;
      win_q[1] <= mid_rd_q;
      win_q[2] <= pixel_in_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: registered sum
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_xfer && res_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_sum_q  <= sum_d;
      s1_fend_q <= last_col && last_row;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: divide by nine into the output register
  // --------------------------------------------------------------------------
  logic [bb3s_pkg::PROD_W-1:0] prod;
  logic [PIX_W-1:0]            quot_d, pix_q;
  logic                        fend_q;

  assign prod   = bb3s_pkg::PROD_W'(s1_sum_q) * bb3s_pkg::PROD_W'(bb3s_pkg::DIV9_RECIP);
  assign quot_d = prod[bb3s_pkg::DIV9_SHIFT +: PIX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      pix_q  <= quot_d;
      fend_q <= s1_fend_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blurred_pixel_o = pix_q;
  assign frame_end_o     = fend_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_counters_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= COL_LAST_MAX) && (row_q <= ROW_LAST_MAX))
    else $error("position counter beyond the frame maximum");

  a_interior_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && res_hit) |=> s1_valid_q)
    else $error("interior pixel transfer produced no result");

  a_stage_moves_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("sum stage advanced without filling the output register");

endmodule : box_blur_3x3_stream
`default_nettype wire
